// ===== rtl/acc_pkg.sv =====
`default_nettype none

package acc_pkg;

  // mode machine codes
  localparam logic [3:0] MODE_NORMAL  = 4'd0;
  localparam logic [3:0] MODE_RING    = 4'd1;
  localparam logic [3:0] MODE_FORMAT  = 4'd2;
  localparam logic [3:0] MODE_ADJ_HR  = 4'd3;
  localparam logic [3:0] MODE_ADJ_MIN = 4'd4;
  localparam logic [3:0] MODE_ADJ_SEC = 4'd5;
  localparam logic [3:0] MODE_ALM_HR  = 4'd6;
  localparam logic [3:0] MODE_ALM_MIN = 4'd7;
  localparam logic [3:0] MODE_ALM_SEC = 4'd8;

  // day suffix codes
  localparam logic [1:0] SUFFIX_BLANK = 2'd0;
  localparam logic [1:0] SUFFIX_AM    = 2'd1;
  localparam logic [1:0] SUFFIX_PM    = 2'd2;

  // pending press bits
  localparam int unsigned PEND_SET = 0;
  localparam int unsigned PEND_FMT = 1;
  localparam int unsigned PEND_SEL = 2;
  localparam int unsigned PEND_ALM = 3;

  // config register indexes
  localparam logic REG_MS_PER_PASS   = 1'b0;
  localparam logic REG_MS_PER_SECOND = 1'b1;

  localparam logic [9:0] MS_PER_PASS_RST   = 10'd200;
  localparam logic [9:0] MS_PER_SECOND_RST = 10'd1000;

  typedef struct packed {
    logic [10:0] sub;
    logic [4:0]  hr;
    logic [5:0]  min;
    logic [5:0]  sec;
  } time_t;

  function automatic logic [4:0] inc_hr(input logic [4:0] v);
    return (v >= 5'd23) ? 5'd0 : v + 5'd1;
  endfunction

  function automatic logic [5:0] inc_60(input logic [5:0] v);
    return (v >= 6'd59) ? 6'd0 : v + 6'd1;
  endfunction

  function automatic time_t add_ms(input time_t t, input logic [9:0] mpp);
    time_t r;
    r = t;
    r.sub = t.sub + {1'b0, mpp};
    return r;
  endfunction

  // second tick from the sub-second counter, then carries
  function automatic time_t check_clock(input time_t t, input logic [9:0] mps);
    time_t r;
    r = t;
    if (r.sub >= {1'b0, mps}) begin
      r.sec = r.sec + 6'd1;
      r.sub = '0;
    end
    if (r.sec >= 6'd60) begin
      r.sec = '0;
      r.min = r.min + 6'd1;
      if (r.min >= 6'd60) begin
        r.min = '0;
        r.hr  = r.hr + 5'd1;
        if (r.hr >= 5'd24) begin
          r.hr = '0;
        end
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/alarm_clock_controller.sv =====
// result path: an accepted item waits in the input register, then its result is held in the result register
// throughput: one item per cycle while the output does not stall; the whole pass is one combinational step
// between the input register and the result register
// reset: clock 20:00:00, alarm 20:00:03, 24h mode, alarm armed, normal mode,
// led high, no pending presses, ms_per_pass 200, ms_per_second 1000
`default_nettype none

module alarm_clock_controller
  import acc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // item in
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        press_set_i,
  input  wire logic        press_format_i,
  input  wire logic        press_select_i,
  input  wire logic        press_alarm_i,
  // item out
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [4:0]       shown_hours_o,
  output logic [5:0]       shown_minutes_o,
  output logic [5:0]       shown_seconds_o,
  output logic [1:0]       day_suffix_o,
  output logic [3:0]       panel_mode_o,
  output logic             alarm_armed_o,
  output logic             alarm_led_o,
  output logic             buzzer_pulse_o,
  // config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [9:0] ms_per_pass_q;
  logic [9:0] ms_per_second_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_per_pass_q   <= MS_PER_PASS_RST;
      ms_per_second_q <= MS_PER_SECOND_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MS_PER_PASS) begin
        ms_per_pass_q <= pwdata[9:0];
      end else begin
        ms_per_second_q <= pwdata[9:0];
      end
    end
  end

  // reads are combinational, zero extended
  always_comb begin
    case (paddr[2])
      REG_MS_PER_PASS:   prdata = {22'd0, ms_per_pass_q};
      REG_MS_PER_SECOND: prdata = {22'd0, ms_per_second_q};
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // handshake: input register, then result register
  // the result register frees itself the cycle it is taken, so a new item
  // can move through every cycle; stall goes back only when a held result
  // blocks the item waiting in the input register
  // ---------------------------------------------------------------------------
  logic       in_vld_q;
  logic [3:0] press_q;
  logic       out_vld_q;
  logic       out_free;
  logic       adv;
  logic       in_acc;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign adv        = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // press bits: set, format, select, alarm
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      press_q <= {press_alarm_i, press_select_i, press_format_i, press_set_i};
    end
  end

  // ---------------------------------------------------------------------------
  // controller state
  // ---------------------------------------------------------------------------
  time_t      clk_q, clk_d;
  logic [4:0] wake_hr_q, wake_hr_d;
  logic [5:0] wake_min_q, wake_min_d;
  logic [5:0] wake_sec_q, wake_sec_d;
  logic       fmt24_q, fmt24_d;
  logic       wake_en_q, wake_en_d;
  logic [3:0] mode_q, mode_d;
  logic       blink_q, blink_d;
  logic       led_q, led_d;
  logic [3:0] pend_q, pend_d;

  // pass logic
  logic [3:0] pend;
  logic [3:0] ran;
  logic       buzz;
  time_t      clk_chk;
  logic       wake_hit;

  assign pend = pend_q | press_q;
  // unused codes behave as normal mode
  assign ran  = (mode_q > MODE_ALM_SEC) ? MODE_NORMAL : mode_q;

  // normal mode checks the clock before adding the step
  assign clk_chk  = check_clock(clk_q, ms_per_second_q);
  assign wake_hit = wake_en_q && (clk_chk.sec == wake_sec_q) &&
                    (clk_chk.min == wake_min_q) && (clk_chk.hr == wake_hr_q);

  always_comb begin
    clk_d      = clk_q;
    wake_hr_d  = wake_hr_q;
    wake_min_d = wake_min_q;
    wake_sec_d = wake_sec_q;
    fmt24_d    = fmt24_q;
    wake_en_d  = wake_en_q;
    mode_d     = mode_q;
    blink_d    = blink_q;
    led_d      = led_q;
    pend_d     = pend;
    buzz       = 1'b0;

    case (ran)
      MODE_RING: begin
        // ringing adds the step before the check
        clk_d   = check_clock(add_ms(clk_q, ms_per_pass_q), ms_per_second_q);
        blink_d = !blink_q;
        led_d   = !blink_q;
        if (pend[PEND_ALM]) begin
          pend_d[PEND_ALM] = 1'b0;
          blink_d          = 1'b1;
          led_d            = 1'b1;
          mode_d           = MODE_NORMAL;
        end
        buzz = 1'b1;
      end
      MODE_FORMAT: begin
        fmt24_d = !fmt24_q;
        mode_d  = MODE_NORMAL;
      end
      MODE_ADJ_HR: begin
        if (pend[PEND_SET]) begin
          pend_d[PEND_SET] = 1'b0;
          clk_d.hr         = inc_hr(clk_q.hr);
        end else if (pend[PEND_SEL]) begin
          pend_d[PEND_SEL] = 1'b0;
          mode_d           = MODE_ADJ_MIN;
        end
      end
      MODE_ADJ_MIN: begin
        // set and select both act in the same pass
        if (pend[PEND_SET]) begin
          pend_d[PEND_SET] = 1'b0;
          clk_d.min        = inc_60(clk_q.min);
        end
        if (pend[PEND_SEL]) begin
          pend_d[PEND_SEL] = 1'b0;
          mode_d           = MODE_ADJ_SEC;
        end
      end
      MODE_ADJ_SEC: begin
        if (pend[PEND_SET]) begin
          pend_d[PEND_SET] = 1'b0;
          clk_d.sec        = inc_60(clk_q.sec);
        end
        if (pend[PEND_SEL]) begin
          pend_d[PEND_SEL] = 1'b0;
          mode_d           = MODE_NORMAL;
        end
      end
      MODE_ALM_HR, MODE_ALM_MIN, MODE_ALM_SEC: begin
        if (pend[PEND_SET]) begin
          pend_d[PEND_SET] = 1'b0;
          if (ran == MODE_ALM_HR) begin
            wake_hr_d = inc_hr(wake_hr_q);
          end else if (ran == MODE_ALM_MIN) begin
            wake_min_d = inc_60(wake_min_q);
          end else begin
            wake_sec_d = inc_60(wake_sec_q);
          end
        end else if (pend[PEND_ALM]) begin
          // alarm button leaves and disarms
          pend_d[PEND_ALM] = 1'b0;
          mode_d           = MODE_NORMAL;
          wake_en_d        = 1'b0;
        end else if (pend[PEND_SEL]) begin
          pend_d[PEND_SEL] = 1'b0;
          if (ran == MODE_ALM_SEC) begin
            mode_d    = MODE_NORMAL;
            wake_en_d = 1'b1;
          end else begin
            mode_d = ran + 4'd1;
          end
        end
        // the clock keeps running while the alarm is edited
        clk_d = check_clock(add_ms(clk_q, ms_per_pass_q), ms_per_second_q);
      end
      default: begin
        mode_d = MODE_NORMAL;
        if (wake_hit) begin
          mode_d = MODE_RING;
        end else if (pend[PEND_FMT]) begin
          pend_d[PEND_FMT] = 1'b0;
          mode_d           = MODE_FORMAT;
        end else if (pend[PEND_SEL]) begin
          pend_d[PEND_SEL] = 1'b0;
          mode_d           = MODE_ADJ_HR;
        end else if (pend[PEND_ALM]) begin
          pend_d[PEND_ALM] = 1'b0;
          mode_d           = MODE_ALM_HR;
        end
        clk_d = add_ms(clk_chk, ms_per_pass_q);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_q      <= '{sub: 11'd0, hr: 5'd20, min: 6'd0, sec: 6'd0};
      wake_hr_q  <= 5'd20;
      wake_min_q <= 6'd0;
      wake_sec_q <= 6'd3;
      fmt24_q    <= 1'b1;
      wake_en_q  <= 1'b1;
      mode_q     <= MODE_NORMAL;
      blink_q    <= 1'b0;
      led_q      <= 1'b1;
      pend_q     <= '0;
    end else if (adv) begin
      clk_q      <= clk_d;
      wake_hr_q  <= wake_hr_d;
      wake_min_q <= wake_min_d;
      wake_sec_q <= wake_sec_d;
      fmt24_q    <= fmt24_d;
      wake_en_q  <= wake_en_d;
      mode_q     <= mode_d;
      blink_q    <= blink_d;
      led_q      <= led_d;
      pend_q     <= pend_d;
    end
  end

  // ---------------------------------------------------------------------------
  // display: alarm time while editing the alarm, the clock otherwise,
  // both taken after the pass
  // ---------------------------------------------------------------------------
  logic [4:0] disp_hr;
  logic [5:0] disp_min;
  logic [5:0] disp_sec;
  logic [4:0] hr_shown;
  logic [1:0] suffix;

  always_comb begin
    if (ran >= MODE_ALM_HR) begin
      disp_hr  = wake_hr_d;
      disp_min = wake_min_d;
      disp_sec = wake_sec_d;
    end else begin
      disp_hr  = clk_d.hr;
      disp_min = clk_d.min;
      disp_sec = clk_d.sec;
    end

    hr_shown = disp_hr;
    suffix   = SUFFIX_BLANK;
    if (!fmt24_d) begin
      if (disp_hr == 5'd0) begin
        hr_shown = 5'd12;
      end else if (disp_hr > 5'd12) begin
        hr_shown = disp_hr - 5'd12;
      end
      // suffix follows the 24h value of the displayed hour
      suffix = (disp_hr >= 5'd12) ? SUFFIX_PM : SUFFIX_AM;
    end
  end

  // result register
  logic [4:0] shown_hours_q;
  logic [5:0] shown_minutes_q;
  logic [5:0] shown_seconds_q;
  logic [1:0] day_suffix_q;
  logic [3:0] panel_mode_q;
  logic       alarm_armed_q;
  logic       alarm_led_q;
  logic       buzzer_pulse_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      shown_hours_q   <= hr_shown;
      shown_minutes_q <= disp_min;
      shown_seconds_q <= disp_sec;
      day_suffix_q    <= suffix;
      panel_mode_q    <= ran;
      alarm_armed_q   <= wake_en_d;
      alarm_led_q     <= led_d;
      buzzer_pulse_q  <= buzz;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign shown_hours_o   = shown_hours_q;
  assign shown_minutes_o = shown_minutes_q;
  assign shown_seconds_o = shown_seconds_q;
  assign day_suffix_o    = day_suffix_q;
  assign panel_mode_o    = panel_mode_q;
  assign alarm_armed_o   = alarm_armed_q;
  assign alarm_led_o     = alarm_led_q;
  assign buzzer_pulse_o  = buzzer_pulse_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // the buzzer only sounds on a ringing pass
  a_buzz_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && buzzer_pulse_q) |-> (panel_mode_q == MODE_RING))
    else $error("buzzer pulse outside ringing mode");

  // 12h display keeps the hour in 1..12
  a_hr12_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && day_suffix_q != SUFFIX_BLANK) |->
      (shown_hours_q >= 5'd1 && shown_hours_q <= 5'd12))
    else $error("12h hour out of range");

  // time of day stays in range
  a_clock_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (clk_q.sec < 6'd60 && clk_q.min < 6'd60 && clk_q.hr < 5'd24))
    else $error("clock field out of range");

  // controller state moves only when an item passes to the result register
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(mode_q) && $stable(clk_q) && $stable(pend_q)))
    else $error("controller state changed without a pass");

endmodule

`default_nettype wire
